>>> design/framed_packet_receiver_crc16_macros.svh
// Assertion helpers for the framed packet receiver.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef FRAMED_PACKET_RECEIVER_CRC16_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CRC16_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define FRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define FRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FRP_ASSERT_IMP(lbl, ante, cons, msg)
`define FRP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/frp_pkg.sv
package frp_pkg;

  localparam int unsigned PAYLOAD_LIMIT_DEF = 256;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // frame marks
  localparam logic [7:0] SOF1_BYTE = 8'h48;
  localparam logic [7:0] SOF2_BYTE = 8'h4A;
  localparam logic [7:0] EOF1_BYTE = 8'h4A;
  localparam logic [7:0] EOF2_BYTE = 8'h4C;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // register reset values
  localparam logic [15:0] TIMEOUT_RST   = 16'd100;
  localparam logic [7:0]  REPLY_OK_RST  = 8'd1;
  localparam logic [7:0]  PAGE_TYPE_RST = 8'd102;
  localparam logic [7:0]  BEEP_TYPE_RST = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 2'd0,
    CFG_REPLY_OK  = 2'd1,
    CFG_PAGE_TYPE = 2'd2,
    CFG_BEEP_TYPE = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_REPLY   = 3'd2,
    EV_BEEP    = 3'd3,
    EV_FRAME   = 3'd4
  } event_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  reply_ok_code;
    logic [7:0]  page_type_code;
    logic [7:0]  beep_type_code;
  } cfg_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] page_no;
    logic [7:0] frame_type;
    logic [7:0] object_id;
    logic [7:0] payload_length;
  } res_t;

  // reflected CRC-16 update for one byte, LSB first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/frp_cfg.sv
module frp_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  frp_pkg::cfg_idx_t               wr_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0]  wr_data,
  output frp_pkg::cfg_t                   cfg
);
  import frp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks  <= TIMEOUT_RST;
      cfg_r.reply_ok_code  <= REPLY_OK_RST;
      cfg_r.page_type_code <= PAGE_TYPE_RST;
      cfg_r.beep_type_code <= BEEP_TYPE_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TIMEOUT:   cfg_r.timeout_ticks  <= wr_data[15:0];
        CFG_REPLY_OK:  cfg_r.reply_ok_code  <= wr_data[7:0];
        CFG_PAGE_TYPE: cfg_r.page_type_code <= wr_data[7:0];
        CFG_BEEP_TYPE: cfg_r.beep_type_code <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> design/frp_core.sv
module frp_core #(
  parameter int unsigned PAYLOAD_LIMIT = frp_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_en,
  input  frp_pkg::item_t item,
  input  frp_pkg::cfg_t  cfg,
  output frp_pkg::res_t  res
);
  import frp_pkg::*;

  localparam logic [16:0] LIMIT_V = 17'(PAYLOAD_LIMIT);

  typedef enum logic [3:0] {
    ST_HUNT  = 4'd0,
    ST_PAGE  = 4'd1,
    ST_TYPE  = 4'd2,
    ST_OBJ   = 4'd3,
    ST_LENL  = 4'd4,
    ST_LENH  = 4'd5,
    ST_DATA  = 4'd6,
    ST_CSUM  = 4'd7,
    ST_ETX   = 4'd8,
    ST_REPLY = 4'd11
  } state_t;

  state_t      state_r, state_nxt, st_eff;
  logic        pend_r, pend_nxt, pend_eff;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [7:0]  page_r, page_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  obj_r, obj_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  pcount_r, pcount_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] crc_upd;
  logic [15:0] len_new;
  logic        timeout;
  logic [7:0]  b;
  event_t      ev;
  logic [7:0]  pbyte, pidx;

  assign b       = item.rx_byte;
  assign crc_upd = crc_step(crc_r, b);
  assign len_new = {b, len_r[7:0]};
  assign timeout = (idle_r >= cfg.timeout_ticks);
  assign st_eff  = timeout ? ST_HUNT : state_r;
  assign pend_eff = timeout ? 1'b0 : pend_r;

  always_comb begin
    state_nxt  = state_r;
    pend_nxt   = pend_r;
    crc_nxt    = crc_r;
    rcrc_nxt   = rcrc_r;
    page_nxt   = page_r;
    type_nxt   = type_r;
    obj_nxt    = obj_r;
    len_nxt    = len_r;
    pcount_nxt = pcount_r;
    idle_nxt   = idle_r;
    ev         = EV_NONE;
    pbyte      = 8'h00;
    pidx       = 8'h00;
    if (!item.op) begin
      if (idle_r != 16'hFFFF) idle_nxt = idle_r + 16'd1;
    end else begin
      idle_nxt  = 16'd0;
      state_nxt = st_eff;
      pend_nxt  = pend_eff;
      case (st_eff)
        ST_REPLY: begin
          page_nxt  = b;
          state_nxt = ST_HUNT;
          ev        = EV_REPLY;
        end
        ST_PAGE: begin
          page_nxt  = b;
          crc_nxt   = crc_upd;
          state_nxt = ST_TYPE;
        end
        ST_TYPE: begin
          type_nxt = b;
          crc_nxt  = crc_upd;
          if (b == cfg.page_type_code) begin
            state_nxt = ST_CSUM;
          end else if (b == cfg.beep_type_code) begin
            state_nxt = ST_HUNT;
            ev        = EV_BEEP;
          end else begin
            state_nxt = ST_OBJ;
          end
        end
        ST_OBJ: begin
          obj_nxt   = b;
          crc_nxt   = crc_upd;
          len_nxt   = 16'd0;
          state_nxt = ST_LENL;
        end
        ST_LENL: begin
          len_nxt   = {8'h00, b};
          crc_nxt   = crc_upd;
          state_nxt = ST_LENH;
        end
        ST_LENH: begin
          len_nxt = len_new;
          crc_nxt = crc_upd;
          if (len_new == 16'd0) begin
            state_nxt = ST_CSUM;
          end else if ({1'b0, len_new} >= LIMIT_V) begin
            state_nxt = ST_HUNT;
          end else begin
            pcount_nxt = 8'd0;
            state_nxt  = ST_DATA;
          end
        end
        ST_DATA: begin
          crc_nxt = crc_upd;
          ev      = EV_PAYLOAD;
          pbyte   = b;
          pidx    = pcount_r;
          if (({8'h00, pcount_r} + 16'd1) >= len_r) state_nxt = ST_CSUM;
          pcount_nxt = pcount_r + 8'd1;
        end
        ST_CSUM: begin
          if (pend_eff) begin
            pend_nxt  = 1'b0;
            rcrc_nxt  = {b, rcrc_r[7:0]};
            state_nxt = ST_ETX;
          end else begin
            pend_nxt = 1'b1;
            rcrc_nxt = {8'h00, b};
          end
        end
        ST_ETX: begin
          if (b == EOF1_BYTE) begin
            pend_nxt = 1'b1;
          end else begin
            if (pend_eff) begin
              pend_nxt = 1'b0;
              if (b == EOF2_BYTE && crc_r == rcrc_r) ev = EV_FRAME;
            end
            state_nxt = ST_HUNT;
          end
        end
        default: begin
          // hunt: reply code takes priority over the start mark
          state_nxt = ST_HUNT;
          if (b == cfg.reply_ok_code) begin
            type_nxt  = b;
            pend_nxt  = 1'b0;
            state_nxt = ST_REPLY;
          end else if (b == SOF1_BYTE) begin
            pend_nxt = 1'b1;
          end else if (pend_eff) begin
            pend_nxt = 1'b0;
            if (b == SOF2_BYTE) begin
              crc_nxt   = CRC_INIT;
              state_nxt = ST_PAGE;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_HUNT;
      pend_r   <= 1'b0;
      crc_r    <= 16'd0;
      rcrc_r   <= 16'd0;
      page_r   <= 8'd0;
      type_r   <= 8'd0;
      obj_r    <= 8'd0;
      len_r    <= 16'd0;
      pcount_r <= 8'd0;
      idle_r   <= 16'd0;
    end else if (step_en) begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      crc_r    <= crc_nxt;
      rcrc_r   <= rcrc_nxt;
      page_r   <= page_nxt;
      type_r   <= type_nxt;
      obj_r    <= obj_nxt;
      len_r    <= len_nxt;
      pcount_r <= pcount_nxt;
      idle_r   <= idle_nxt;
    end
  end

  always_comb begin
    res.event_res      = ev;
    res.payload_byte   = pbyte;
    res.payload_index  = pidx;
    res.page_no        = page_nxt;
    res.frame_type     = type_nxt;
    res.object_id      = obj_nxt;
    res.payload_length = len_nxt[7:0];
  end

endmodule

>>> design/framed_packet_receiver_crc16.sv
// Framed packet receiver with CRC-16 check. Each input item is either a
// time tick (in_op = 0) or one received UART byte (in_op = 1), and every
// item yields exactly one result item. A byte that arrives after at least
// timeout_ticks idle ticks restarts the hunt for a frame start. The block
// recognizes a short reply (reply code, then page byte) and frames of the
// form 0x48 0x4A, page, type, object id, length low/high, payload,
// checksum low/high, 0x4A 0x4C. Payload bytes stream out as event 1 as
// they arrive; a beep type gives event 3 right after the type byte; a
// frame whose reflected CRC-16 (poly 0xA001, init 0xFFFF over page through
// payload) matches gives event 4 after the end mark. Lengths at or above
// PAYLOAD_LIMIT drop the frame. The block takes one item per clock unless
// the output side stalls: an item is held in the input register, then the
// whole parser step, including the byte-wide CRC update, is computed
// combinationally into the output register, which offers the result.
// in_stall rises only while both registers are full and the output side
// stalls. Configuration writes are always ready and take effect at once;
// write them only while no item is in flight.
`include "framed_packet_receiver_crc16_macros.svh"

module framed_packet_receiver_crc16 #(
  parameter int unsigned PAYLOAD_LIMIT = frp_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [7:0]                     in_rx_byte,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_event_res,
  output logic [7:0]                     out_payload_byte,
  output logic [7:0]                     out_payload_index,
  output logic [7:0]                     out_page_no,
  output logic [7:0]                     out_frame_type,
  output logic [7:0]                     out_object_id,
  output logic [7:0]                     out_payload_length,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [frp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import frp_pkg::*;

  // input register
  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;

  // output register
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;

  logic  in_take;
  logic  advance;
  cfg_t  cfg;
  res_t  step_res;

  // Advance the held item whenever the output register is free or drains now.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  // Hold input only when the input register cannot move on.
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  frp_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_idx_t'(cfg_index)),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  frp_core #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on handshake, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.op      <= in_op;
      s1_item_r.rx_byte <= in_rx_byte;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = out_res_r.event_res;
  assign out_payload_byte   = out_res_r.payload_byte;
  assign out_payload_index  = out_res_r.payload_index;
  assign out_page_no        = out_res_r.page_no;
  assign out_frame_type     = out_res_r.frame_type;
  assign out_object_id      = out_res_r.object_id;
  assign out_payload_length = out_res_r.payload_length;

  // A streamed payload byte always lies inside the announced length.
  `FRP_ASSERT_IMP(a_pidx_in_len, out_valid && (out_event_res == EV_PAYLOAD), out_payload_index < out_payload_length, "payload index outside frame length")
  // Only payload events carry a byte and index.
  `FRP_ASSERT_IMP(a_nonpayload_zero, out_valid && (out_event_res != EV_PAYLOAD), (out_payload_byte == 8'h00) && (out_payload_index == 8'h00), "payload fields set on non-payload event")
  // Input backpressure comes only from a held result.
  `FRP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")
  // A step always lands a result in the output register.
  `FRP_ASSERT_NXT(a_step_lands, s1_valid_r && !in_stall, out_valid, "advanced item did not reach output register")

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

package frame_check_pkg;
  import frp_pkg::*;

  typedef enum logic [3:0] {
    PS_HUNT, PS_PAGE, PS_TYPE, PS_OBJ, PS_LENL, PS_LENH, PS_DATA, PS_CSUM, PS_ETX, PS_REPLY
  } parse_state_t;

  class frame_tracker;
    // register copies
    logic [15:0]  timeout_ticks;
    logic [7:0]   reply_code;
    logic [7:0]   page_type;
    logic [7:0]   beep_type;
    // parser copy
    parse_state_t st;
    logic         hi_pending;
    logic [15:0]  crc;
    logic [15:0]  rx_crc;
    logic [7:0]   page;
    logic [7:0]   ftype;
    logic [7:0]   obj;
    logic [15:0]  len;
    logic [7:0]   count;
    logic [15:0]  idle_cnt;

    res_t         expected_events[$];
    int           accepted;
    int           checked;
    int           mismatches;

    function new();
      timeout_ticks = TIMEOUT_RST;
      reply_code    = REPLY_OK_RST;
      page_type     = PAGE_TYPE_RST;
      beep_type     = BEEP_TYPE_RST;
      st            = PS_HUNT;
      hi_pending    = 1'b0;
      crc           = '0;
      rx_crc        = '0;
      page          = '0;
      ftype         = '0;
      obj           = '0;
      len           = '0;
      count         = '0;
      idle_cnt      = '0;
      accepted      = 0;
      checked       = 0;
      mismatches    = 0;
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      repeat (8) x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
      return x;
    endfunction

    function void set_register(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_TIMEOUT:   timeout_ticks = v;
        CFG_REPLY_OK:  reply_code    = v[7:0];
        CFG_PAGE_TYPE: page_type     = v[7:0];
        CFG_BEEP_TYPE: beep_type     = v[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    // Advance the parser copy by one accepted item and queue its result.
    function void note_item(logic op, logic [7:0] b);
      res_t   r;
      event_t ev;
      logic [7:0] pb;
      logic [7:0] pi;
      ev = EV_NONE;
      pb = '0;
      pi = '0;
      accepted++;
      if (!op) begin
        if (idle_cnt != 16'hFFFF) idle_cnt++;
      end else begin
        if (idle_cnt >= timeout_ticks) begin
          st = PS_HUNT;
          hi_pending = 1'b0;
        end
        idle_cnt = '0;
        case (st)
          PS_REPLY: begin
            page = b;
            st = PS_HUNT;
            ev = EV_REPLY;
          end
          PS_PAGE: begin
            page = b;
            crc = crc_byte(crc, b);
            st = PS_TYPE;
          end
          PS_TYPE: begin
            ftype = b;
            crc = crc_byte(crc, b);
            if (b == page_type) st = PS_CSUM;
            else if (b == beep_type) begin
              st = PS_HUNT;
              ev = EV_BEEP;
            end else st = PS_OBJ;
          end
          PS_OBJ: begin
            obj = b;
            crc = crc_byte(crc, b);
            len = '0;
            st = PS_LENL;
          end
          PS_LENL: begin
            len = {8'h00, b};
            crc = crc_byte(crc, b);
            st = PS_LENH;
          end
          PS_LENH: begin
            len = {b, len[7:0]};
            crc = crc_byte(crc, b);
            if (len == 16'd0) st = PS_CSUM;
            else if (len >= PAYLOAD_LIMIT_DEF) st = PS_HUNT;
            else begin
              count = '0;
              st = PS_DATA;
            end
          end
          PS_DATA: begin
            crc = crc_byte(crc, b);
            ev = EV_PAYLOAD;
            pb = b;
            pi = count;
            if ({8'h00, count} + 16'd1 >= len) st = PS_CSUM;
            count = count + 8'd1;
          end
          PS_CSUM: begin
            if (hi_pending) begin
              hi_pending = 1'b0;
              rx_crc = {b, rx_crc[7:0]};
              st = PS_ETX;
            end else begin
              hi_pending = 1'b1;
              rx_crc = {8'h00, b};
            end
          end
          PS_ETX: begin
            if (b == EOF1_BYTE) hi_pending = 1'b1;
            else begin
              if (hi_pending) begin
                hi_pending = 1'b0;
                if (b == EOF2_BYTE && crc == rx_crc) ev = EV_FRAME;
              end
              st = PS_HUNT;
            end
          end
          default: begin
            st = PS_HUNT;
            if (b == reply_code) begin
              ftype = b;
              hi_pending = 1'b0;
              st = PS_REPLY;
            end else if (b == SOF1_BYTE) hi_pending = 1'b1;
            else if (hi_pending) begin
              hi_pending = 1'b0;
              if (b == SOF2_BYTE) begin
                crc = CRC_INIT;
                st = PS_PAGE;
              end
            end
          end
        endcase
      end
      r.event_res      = ev;
      r.payload_byte   = pb;
      r.payload_index  = pi;
      r.page_no        = page;
      r.frame_type     = ftype;
      r.object_id      = obj;
      r.payload_length = len[7:0];
      expected_events.push_back(r);
    endfunction

    function string show(res_t r);
      return $sformatf("ev=%0d byte=%02h idx=%0d page=%02h type=%02h obj=%02h len=%0d",
                       r.event_res, r.payload_byte, r.payload_index, r.page_no,
                       r.frame_type, r.object_id, r.payload_length);
    endfunction

    function void check_item(res_t got);
      res_t want;
      checked++;
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: %s", checked, show(got));
        return;
      end
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res || got.payload_byte !== want.payload_byte ||
          got.payload_index !== want.payload_index || got.page_no !== want.page_no ||
          got.frame_type !== want.frame_type || got.object_id !== want.object_id ||
          got.payload_length !== want.payload_length) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d expected %s", checked, show(want));
          $display("result %0d got      %s", checked, show(got));
        end
      end
    endfunction
  endclass
endpackage

module tb;
  import frp_pkg::*;
  import frame_check_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 70;

  typedef enum {FL_NONE, FL_CRC, FL_END, FL_EXTRA_ETX, FL_CUT} frame_flaw_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_op;
  logic [7:0]            in_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [2:0]            out_event_res;
  logic [7:0]            out_payload_byte;
  logic [7:0]            out_payload_index;
  logic [7:0]            out_page_no;
  logic [7:0]            out_frame_type;
  logic [7:0]            out_object_id;
  logic [7:0]            out_payload_length;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  frame_tracker sb;

  // Pacing controls shared by the sender and the receiver.
  bit sender_quiet;  // sender offers back to back
  bit rcv_quiet;     // receiver never stalls
  bit force_quiet;   // both sides run flat out
  int hold_cycles;   // one long receiver hold-off, consumed by the sink
  int cycle_count;

  framed_packet_receiver_crc16 dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_page_no        (out_page_no),
    .out_frame_type     (out_frame_type),
    .out_object_id      (out_object_id),
    .out_payload_length (out_payload_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Kill the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[framed_packet_receiver_crc16] ERROR");
      $finish;
    end
  end

  // Offer one item after a random gap, then hold it until the block takes it.
  // Leave in_valid high afterwards so a back-to-back item needs no re-raise.
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    gap = (sender_quiet || force_quiet) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_item(op, b);
  endtask

  // Stop offering and wait until every predicted result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_register(idx, v);
  endtask

  // Write all four registers back to back; only call with the block drained.
  task automatic write_config(input logic [15:0] tmo, input logic [7:0] reply,
                              input logic [7:0] page_code, input logic [7:0] beep_code);
    cfg_valid <= 1'b1;
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_REPLY_OK, {8'h00, reply});
    write_reg(CFG_PAGE_TYPE, {8'h00, page_code});
    write_reg(CFG_BEEP_TYPE, {8'h00, beep_code});
    cfg_valid <= 1'b0;
  endtask

  // Build one framed message with random page, object and payload, and send
  // it byte by byte. A flaw corrupts the checksum or the end mark, repeats the
  // first end byte, or cuts the frame short. Short tick runs that stay under the timeout are sprinkled in.
  task automatic send_frame(input frame_flaw_t flaw, input logic [7:0] ftype,
                            input logic [15:0] len);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    int          n_send;
    bytes.push_back(SOF1_BYTE);
    bytes.push_back(SOF2_BYTE);
    bytes.push_back(8'($urandom));
    bytes.push_back(ftype);
    if (ftype != sb.page_type && ftype != sb.beep_type) begin
      bytes.push_back(8'($urandom));
      bytes.push_back(len[7:0]);
      bytes.push_back(len[15:8]);
      if (len < PAYLOAD_LIMIT_DEF)
        repeat (len) bytes.push_back(8'($urandom));
    end
    crc = CRC_INIT;
    for (int i = 2; i < bytes.size(); i++) crc = sb.crc_byte(crc, bytes[i]);
    if (flaw == FL_CRC) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    // beep frames and oversized lengths carry no tail
    if (ftype == sb.page_type ||
        (ftype != sb.beep_type && len < PAYLOAD_LIMIT_DEF)) begin
      bytes.push_back(crc[7:0]);
      bytes.push_back(crc[15:8]);
      if (flaw == FL_END) begin
        if ($urandom_range(0, 1) == 0) bytes.push_back(EOF2_BYTE);
        else begin
          bytes.push_back(EOF1_BYTE);
          bytes.push_back(8'($urandom));
        end
      end else begin
        if (flaw == FL_EXTRA_ETX) repeat ($urandom_range(1, 3)) bytes.push_back(EOF1_BYTE);
        bytes.push_back(EOF1_BYTE);
        bytes.push_back(EOF2_BYTE);
      end
    end
    n_send = (flaw == FL_CUT) ? $urandom_range(1, bytes.size() - 1) : bytes.size();
    for (int i = 0; i < n_send; i++) begin
      if (sb.timeout_ticks > 16'd3 && $urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 2)) send_item(1'b0, 8'($urandom));
      send_item(1'b1, bytes[i]);
    end
  endtask

  // Mostly well-formed frames with random content; the rest is replies,
  // noise around the frame marks, short tick runs and timeout-boundary idles.
  task automatic random_traffic(input int count);
    int          stop_at;
    int          pick;
    logic [7:0]  ftype;
    logic [7:0]  b;
    logic [15:0] len;
    frame_flaw_t flaw;
    stop_at = sb.accepted + count;
    while (sb.accepted < stop_at) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        case ($urandom_range(0, 5))
          0:       ftype = sb.page_type;
          1:       ftype = sb.beep_type;
          default: ftype = 8'($urandom);
        endcase
        case ($urandom_range(0, 19))
          0, 1:    len = 16'd0;
          2:       len = 16'd256;
          3:       len = {8'($urandom_range(1, 255)), 8'($urandom)};
          4, 5:    len = 16'($urandom_range(7, 40));
          default: len = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
          0:       flaw = FL_CRC;
          1:       flaw = FL_END;
          2:       flaw = FL_EXTRA_ETX;
          3:       flaw = FL_CUT;
          default: flaw = FL_NONE;
        endcase
        send_frame(flaw, ftype, len);
      end else if (pick < 75) begin
        send_item(1'b1, sb.reply_code);
        send_item(1'b1, 8'($urandom));
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 4))
            0:       b = SOF1_BYTE;
            1:       b = SOF2_BYTE;
            2:       b = EOF2_BYTE;
            3:       b = sb.reply_code;
            default: b = 8'($urandom);
          endcase
          send_item(1'b1, b);
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 8)) send_item(1'b0, 8'($urandom));
      end else if (sb.timeout_ticks <= 16'd120) begin
        // land exactly on the timeout or one tick short of it
        repeat (int'(sb.timeout_ticks) - int'($urandom_range(0, 1)))
          send_item(1'b0, 8'($urandom));
      end
    end
  endtask

  // Result sink: stall at random before each result, check it on acceptance.
  initial begin : result_sink
    int   n;
    res_t got;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (force_quiet || rcv_quiet) n = 0;
      else n = $urandom_range(0, 15);
      if ($urandom_range(0, 39) == 0) rcv_quiet = !rcv_quiet;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      got.event_res      = event_t'(out_event_res);
      got.payload_byte   = out_payload_byte;
      got.payload_index  = out_payload_index;
      got.page_no        = out_page_no;
      got.frame_type     = out_frame_type;
      got.object_id      = out_object_id;
      got.payload_length = out_payload_length;
      sb.check_item(got);
    end
  end

  initial begin : stimulus
    sb           = new();
    sender_quiet = 1'b0;
    rcv_quiet    = 1'b0;
    force_quiet  = 1'b0;
    hold_cycles  = 0;
    cycle_count  <= 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= 1'b0;
    in_rx_byte   <= 8'h00;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_TIMEOUT;
    cfg_data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: tick, reply, beep frame, current-page frame, zero-length
    // frame, and a start mark broken by a stray byte.
    send_item(1'b0, 8'hFF);
    send_item(1'b1, REPLY_OK_RST);
    send_item(1'b1, 8'hFF);
    send_frame(FL_NONE, BEEP_TYPE_RST, 16'd0);
    send_frame(FL_NONE, PAGE_TYPE_RST, 16'd0);
    send_frame(FL_NONE, 8'h00, 16'd0);
    send_item(1'b1, SOF1_BYTE);
    send_item(1'b1, 8'h55);
    random_traffic(PHASE_ITEMS);

    // Longest timeout. Hold the sink off while the sender pushes a full
    // frame back to back so the block backs up into its input.
    drain();
    write_config(16'hFFFF, 8'h00, 8'hFF, 8'h00);
    hold_cycles  = 300;
    sender_quiet = 1'b1;
    send_frame(FL_NONE, 8'h33, 16'd8);
    random_traffic(PHASE_ITEMS);

    // Long idle run mid-frame, flat out on both sides; it stays under the
    // longest timeout, so the frame carries on with the following bytes.
    force_quiet = 1'b1;
    send_item(1'b1, SOF1_BYTE);
    send_item(1'b1, SOF2_BYTE);
    send_item(1'b1, 8'h5A);
    repeat (40) send_item(1'b0, 8'($urandom));
    send_item(1'b1, SOF1_BYTE);
    send_item(1'b1, SOF2_BYTE);
    force_quiet = 1'b0;

    // Shortest timeout, equal page and beep codes (page meaning wins).
    drain();
    write_config(16'd1, 8'hFF, 8'h10, 8'h10);
    random_traffic(PHASE_ITEMS);

    // Reply code collides with the first start byte.
    drain();
    write_config(16'd5, SOF1_BYTE, 8'h66, 8'h02);
    random_traffic(PHASE_ITEMS);

    // Codes sitting on the frame marks.
    drain();
    write_config(16'd12, EOF1_BYTE, EOF2_BYTE, 8'hA5);
    random_traffic(PHASE_ITEMS);

    drain();
    write_config(16'($urandom_range(1, 60)), 8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(PHASE_ITEMS);

    // Back to reset values, with one frame of the largest legal payload.
    drain();
    write_config(TIMEOUT_RST, REPLY_OK_RST, PAGE_TYPE_RST, BEEP_TYPE_RST);
    send_frame(FL_NONE, 8'h00, 16'd255);
    random_traffic(PHASE_ITEMS);

    drain();
    // catch any stray result after the last expected one
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("[framed_packet_receiver_crc16] OK");
    else
      $display("[framed_packet_receiver_crc16] ERROR");
    $finish;
  end
endmodule
